### rtl/core/box_collision_side_classifier_defines.svh
// Assertion macros used by the checker file.
// Each macro expects the clock clk and the active low reset rst_n in scope.
`ifndef BOX_COLLISION_SIDE_CLASSIFIER_DEFINES_SVH
`define BOX_COLLISION_SIDE_CLASSIFIER_DEFINES_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define BCSC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcsc check failed");

// Checks that cons follows ante after the delay given by n.
`define BCSC_ASSERT_DELAY(lbl, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("bcsc latency check failed");

`endif

### rtl/core/bcsc_pkg.sv
package bcsc_pkg;

    // Width of the border distance register.
    localparam int BD_BITS = 16;

    // Border distance after reset.
    localparam logic [BD_BITS-1:0] BORDER_RESET = 16'd16;

    // Result codes.
    localparam logic [3:0] HIT_NONE         = 4'd0;
    localparam logic [3:0] HIT_UP           = 4'd1;
    localparam logic [3:0] HIT_UP_BORDER    = 4'd2;
    localparam logic [3:0] HIT_DOWN         = 4'd3;
    localparam logic [3:0] HIT_DOWN_BORDER  = 4'd4;
    localparam logic [3:0] HIT_LEFT         = 4'd5;
    localparam logic [3:0] HIT_LEFT_BORDER  = 4'd6;
    localparam logic [3:0] HIT_RIGHT        = 4'd7;
    localparam logic [3:0] HIT_RIGHT_BORDER = 4'd8;

    // Control flags that travel down the pipeline with each request.
    typedef struct packed {
        logic valid;     // Stage holds a request.
        logic x_left;    // First box center lies left of the second.
        logic y_up;      // First box center lies above the second.
        logic collide;   // Boxes overlap on both axes.
        logic x_border;  // Center distance in x is below the border distance.
        logic y_border;  // Center distance in y is below the border distance.
    } stage_flags_t;

endpackage

### rtl/core/bcsc_delta.sv
module bcsc_delta
    import bcsc_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [COORD_BITS-1:0] own_x,
    input  logic signed [COORD_BITS-1:0] own_y,
    input  logic        [COORD_BITS-2:0] own_half_w,
    input  logic        [COORD_BITS-2:0] own_half_h,
    input  logic signed [COORD_BITS-1:0] other_x,
    input  logic signed [COORD_BITS-1:0] other_y,
    input  logic        [COORD_BITS-2:0] other_half_w,
    input  logic        [COORD_BITS-2:0] other_half_h,
    output logic        [COORD_BITS-1:0] dx,
    output logic        [COORD_BITS-1:0] dy,
    output logic        [COORD_BITS-1:0] sw,
    output logic        [COORD_BITS-1:0] sh,
    output stage_flags_t                 flags
);

    logic [COORD_BITS:0]   diff_x;
    logic [COORD_BITS:0]   diff_y;
    logic [COORD_BITS:0]   neg_x;
    logic [COORD_BITS:0]   neg_y;
    logic [COORD_BITS-1:0] dx_reg, dx_next;
    logic [COORD_BITS-1:0] dy_reg, dy_next;
    logic [COORD_BITS-1:0] sw_reg, sw_next;
    logic [COORD_BITS-1:0] sh_reg, sh_next;
    stage_flags_t          flags_reg, flags_next;

    // Signed center differences; the sign bit tells which box lies first.
    always_comb
    begin
        diff_x = {own_x[COORD_BITS-1], own_x} - {other_x[COORD_BITS-1], other_x};
        diff_y = {own_y[COORD_BITS-1], own_y} - {other_y[COORD_BITS-1], other_y};
        neg_x  = -diff_x;
        neg_y  = -diff_y;
    end

    // Absolute distances and extent sums.
    always_comb
    begin
        dx_next = diff_x[COORD_BITS] ? neg_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
        dy_next = diff_y[COORD_BITS] ? neg_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];
        sw_next = {1'b0, own_half_w} + {1'b0, other_half_w};
        sh_next = {1'b0, own_half_h} + {1'b0, other_half_h};
        flags_next          = '0;
        flags_next.valid    = in_valid;
        flags_next.x_left   = diff_x[COORD_BITS];
        flags_next.y_up     = diff_y[COORD_BITS];
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        sw_reg <= sw_next;
        sh_reg <= sh_next;
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    assign dx    = dx_reg;
    assign dy    = dy_reg;
    assign sw    = sw_reg;
    assign sh    = sh_reg;
    assign flags = flags_reg;

endmodule

### rtl/core/bcsc_product.sv
module bcsc_product
    import bcsc_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [BD_BITS-1:0]        border_distance,
    input  logic [COORD_BITS-1:0]     dx,
    input  logic [COORD_BITS-1:0]     dy,
    input  logic [COORD_BITS-1:0]     sw,
    input  logic [COORD_BITS-1:0]     sh,
    input  stage_flags_t              in_flags,
    output logic [2*COORD_BITS-1:0]   prod_x,
    output logic [2*COORD_BITS-1:0]   prod_y,
    output stage_flags_t              flags
);

    localparam int CMP_BITS = (COORD_BITS > BD_BITS) ? COORD_BITS : BD_BITS;

    logic [CMP_BITS-1:0]     dx_ext;
    logic [CMP_BITS-1:0]     dy_ext;
    logic [CMP_BITS-1:0]     bd_ext;
    logic [2*COORD_BITS-1:0] prod_x_reg, prod_x_next;
    logic [2*COORD_BITS-1:0] prod_y_reg, prod_y_next;
    stage_flags_t            flags_reg, flags_next;

    // Cross products of the normalized center distance ratios.
    always_comb
    begin
        prod_x_next = (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(sh);
        prod_y_next = (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(sw);
    end

    // Overlap test and border tests.
    always_comb
    begin
        dx_ext = CMP_BITS'(dx);
        dy_ext = CMP_BITS'(dy);
        bd_ext = CMP_BITS'(border_distance);
        flags_next          = in_flags;
        flags_next.collide  = (sw != '0) && (sh != '0) && (dx < sw) && (dy < sh);
        flags_next.x_border = dx_ext < bd_ext;
        flags_next.y_border = dy_ext < bd_ext;
    end

    always_ff @(posedge clk)
    begin
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    assign prod_x = prod_x_reg;
    assign prod_y = prod_y_reg;
    assign flags  = flags_reg;

endmodule

### rtl/core/bcsc_decide.sv
module bcsc_decide
    import bcsc_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [2*COORD_BITS-1:0] prod_x,
    input  logic [2*COORD_BITS-1:0] prod_y,
    input  stage_flags_t            in_flags,
    output logic                    done,
    output logic [3:0]              hit_kind
);

    logic       y_side;
    logic       done_reg, done_next;
    logic [3:0] kind_reg, kind_next;

    // A smaller x ratio picks the y side; a tie stays on the x side.
    always_comb
    begin
        y_side = prod_x < prod_y;
        if (!in_flags.collide)
        begin
            kind_next = HIT_NONE;
        end
        else if (y_side)
        begin
            if (in_flags.y_up)
            begin
                kind_next = in_flags.y_border ? HIT_UP_BORDER : HIT_UP;
            end
            else
            begin
                kind_next = in_flags.y_border ? HIT_DOWN_BORDER : HIT_DOWN;
            end
        end
        else
        begin
            if (in_flags.x_left)
            begin
                kind_next = in_flags.x_border ? HIT_LEFT_BORDER : HIT_LEFT;
            end
            else
            begin
                kind_next = in_flags.x_border ? HIT_RIGHT_BORDER : HIT_RIGHT;
            end
        end
        done_next = in_flags.valid;
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign hit_kind = kind_reg;

endmodule

### rtl/core/box_collision_side_classifier.sv
// Channel   Direction  Handshake                Payload
// request   in         start, busy              own_*, other_* box fields
// result    out        done (one-cycle strobe)  hit_kind
// config    in         cfg_valid, cfg_ready     cfg_data (border distance)
//
// Three register stages: distances and extent sums, then the two cross
// products with the overlap and border tests, then the side decision.
// A request taken at one edge passes through the stage-one and stage-two
// registers into the result register, which raises done with its result.
// busy stays low, so a new request is taken every cycle.
// Reset clears the stage valid bits and sets the border distance to 16.
// The receiver cannot stall; each result is shown for exactly one cycle.
module box_collision_side_classifier
    import bcsc_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] own_x,
    input  logic signed [COORD_BITS-1:0] own_y,
    input  logic        [COORD_BITS-2:0] own_half_w,
    input  logic        [COORD_BITS-2:0] own_half_h,
    input  logic signed [COORD_BITS-1:0] other_x,
    input  logic signed [COORD_BITS-1:0] other_y,
    input  logic        [COORD_BITS-2:0] other_half_w,
    input  logic        [COORD_BITS-2:0] other_half_h,
    output logic                         done,
    output logic        [3:0]            hit_kind,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic        [BD_BITS-1:0]    cfg_data
);

    logic [BD_BITS-1:0]      border_reg, border_next;
    logic [COORD_BITS-1:0]   dx, dy, sw, sh;
    logic [2*COORD_BITS-1:0] prod_x, prod_y;
    stage_flags_t            flags_s1, flags_s2;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Border distance register.
    always_comb
    begin
        border_next = (cfg_valid && cfg_ready) ? cfg_data : border_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            border_reg <= BORDER_RESET;
        end
        else
        begin
            border_reg <= border_next;
        end
    end

    // Stage one: distances and extent sums.
    bcsc_delta #(
        .COORD_BITS(COORD_BITS)
    ) u_delta (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start && !busy),
        .own_x        (own_x),
        .own_y        (own_y),
        .own_half_w   (own_half_w),
        .own_half_h   (own_half_h),
        .other_x      (other_x),
        .other_y      (other_y),
        .other_half_w (other_half_w),
        .other_half_h (other_half_h),
        .dx           (dx),
        .dy           (dy),
        .sw           (sw),
        .sh           (sh),
        .flags        (flags_s1)
    );

    // Stage two: cross products and tests.
    bcsc_product #(
        .COORD_BITS(COORD_BITS)
    ) u_product (
        .clk             (clk),
        .rst_n           (rst_n),
        .border_distance (border_reg),
        .dx              (dx),
        .dy              (dy),
        .sw              (sw),
        .sh              (sh),
        .in_flags        (flags_s1),
        .prod_x          (prod_x),
        .prod_y          (prod_y),
        .flags           (flags_s2)
    );

    // Stage three: side decision and result register.
    bcsc_decide #(
        .COORD_BITS(COORD_BITS)
    ) u_decide (
        .clk      (clk),
        .rst_n    (rst_n),
        .prod_x   (prod_x),
        .prod_y   (prod_y),
        .in_flags (flags_s2),
        .done     (done),
        .hit_kind (hit_kind)
    );

endmodule

### rtl/core/bcsc_checker.sv
`include "box_collision_side_classifier_defines.svh"

module bcsc_checker
    import bcsc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [3:0] hit_kind
);

    // Every result comes from an accepted request.
    `BCSC_ASSERT_IMPLY(a_done_has_request, done, $past(start, 3) && !$past(busy, 3))

    // Every accepted request yields a result.
    `BCSC_ASSERT_DELAY(a_request_has_done, start && !busy, 3, done)

    // A result code shown with done is always one of the defined kinds.
    `BCSC_ASSERT_IMPLY(a_kind_range, done, hit_kind <= HIT_RIGHT_BORDER)

endmodule

bind box_collision_side_classifier bcsc_checker u_bcsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .hit_kind (hit_kind)
);
